FILE: sv/compacting_list_with_cursor_top_assert.svh
// Assertion macros for the checks in the top-level file of this block.
`ifndef COMPACTING_LIST_WITH_CURSOR_TOP_ASSERT_SVH
`define COMPACTING_LIST_WITH_CURSOR_TOP_ASSERT_SVH

// The antecedent holding at an edge implies the consequent at the same edge.
`define CLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent holding at an edge implies the consequent at the following edge.
`define CLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/clc_pkg.sv
package clc_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 2;
  localparam int STAT_W   = 2;
  localparam int ENTRY_W  = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_FIRST  = 2'd1,
    MODE_NEXT   = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY_READ = 2'd2,
    ST_NO_CURRENT = 2'd3
  } status_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_INSERT,
    OP_FULL,
    OP_EMPTY,
    OP_NO_CURRENT,
    OP_FIRST,
    OP_NEXT,
    OP_RM_START,
    OP_RD_DONE,
    OP_RM_GET_MORE,
    OP_RM_GET_LAST,
    OP_SHIFT_MORE,
    OP_SHIFT_LAST
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } clc_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic next_ok;
    logic rm_ok;
    logic get_more;
    logic shift_more;
  } clc_flags_t;

endpackage

FILE: sv/clc_ram.sv
module clc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/clc_ctrl.sv
module clc_ctrl import clc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MODE_W-1:0] mode,
  input  clc_flags_t        flags,
  output clc_cmd_t          cmd,
  output logic              busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RM_GET,
    S_SHIFT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (mode_t'(mode))
            MODE_INSERT: begin
              cmd.op = flags.full ? OP_FULL : OP_INSERT;
            end
            MODE_FIRST: begin
              if (flags.empty) begin
                cmd.op = OP_EMPTY;
              end else begin
                cmd.op     = OP_FIRST;
                state_next = S_READ;
              end
            end
            MODE_NEXT: begin
              if (flags.next_ok) begin
                cmd.op     = OP_NEXT;
                state_next = S_READ;
              end else begin
                cmd.op = OP_EMPTY;
              end
            end
            MODE_REMOVE: begin
              if (flags.rm_ok) begin
                cmd.op     = OP_RM_START;
                state_next = S_RM_GET;
              end else begin
                cmd.op = OP_NO_CURRENT;
              end
            end
            default: cmd.op = OP_NOP;
          endcase
        end
      end
      S_READ: begin
        cmd.op     = OP_RD_DONE;
        state_next = S_IDLE;
      end
      S_RM_GET: begin
        if (flags.get_more) begin
          cmd.op     = OP_RM_GET_MORE;
          state_next = S_SHIFT;
        end else begin
          cmd.op     = OP_RM_GET_LAST;
          state_next = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (flags.shift_more) begin
          cmd.op = OP_SHIFT_MORE;
        end else begin
          cmd.op     = OP_SHIFT_LAST;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: sv/clc_dp.sv
module clc_dp import clc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  clc_cmd_t           cmd,
  input  logic [DATA_W-1:0]  data_in,
  output clc_flags_t         flags,
  output logic               done,
  output logic [STAT_W-1:0]  status,
  output logic [DATA_W-1:0]  data_out,
  output logic [ENTRY_W-1:0] entry_count
);

  // The cursor is held as cursor plus one, so zero means no current entry.
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  cur_p1;
  logic [CNT_W-1:0]  cur_p1_next;
  logic [IDX_W-1:0]  sp;
  logic [IDX_W-1:0]  sp_next;
  logic [DATA_W-1:0] got;
  logic [DATA_W-1:0] got_next;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              emit;
  status_t           emit_st;
  logic [DATA_W-1:0] emit_data;

  logic [CNT_W-1:0]  cur_m1;
  logic [CNT_W-1:0]  sp_p1;
  logic [CNT_W-1:0]  sp_p2;

  assign cur_m1 = cur_p1 - CNT_W'(1);
  assign sp_p1  = CNT_W'(sp) + CNT_W'(1);
  assign sp_p2  = CNT_W'(sp) + CNT_W'(2);

  assign flags.full       = (count >= CNT_W'(CAPACITY));
  assign flags.empty      = (count == '0);
  assign flags.next_ok    = (cur_p1 < count);
  assign flags.rm_ok      = (cur_p1 != '0) && (cur_p1 <= count);
  assign flags.get_more   = (sp_p1 < count);
  assign flags.shift_more = (sp_p2 < count);

  always_comb begin
    count_next  = count;
    cur_p1_next = cur_p1;
    sp_next     = sp;
    got_next    = got;
    ram_we      = 1'b0;
    ram_waddr   = sp;
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;
    emit        = 1'b0;
    emit_st     = ST_OK;
    emit_data   = '0;
    unique case (cmd.op)
      OP_NOP: begin
      end
      OP_INSERT: begin
        ram_we     = 1'b1;
        ram_waddr  = count[IDX_W-1:0];
        ram_wdata  = data_in;
        count_next = count + CNT_W'(1);
        emit       = 1'b1;
      end
      OP_FULL: begin
        emit    = 1'b1;
        emit_st = ST_FULL;
      end
      OP_EMPTY: begin
        emit    = 1'b1;
        emit_st = ST_EMPTY_READ;
      end
      OP_NO_CURRENT: begin
        emit    = 1'b1;
        emit_st = ST_NO_CURRENT;
      end
      OP_FIRST: begin
        ram_raddr   = '0;
        cur_p1_next = CNT_W'(1);
      end
      OP_NEXT: begin
        ram_raddr   = cur_p1[IDX_W-1:0];
        cur_p1_next = cur_p1 + CNT_W'(1);
      end
      OP_RM_START: begin
        ram_raddr = cur_m1[IDX_W-1:0];
        sp_next   = cur_m1[IDX_W-1:0];
      end
      OP_RD_DONE: begin
        emit      = 1'b1;
        emit_data = ram_rdata;
      end
      OP_RM_GET_MORE: begin
        got_next  = ram_rdata;
        ram_raddr = sp_p1[IDX_W-1:0];
      end
      OP_RM_GET_LAST: begin
        count_next  = count - CNT_W'(1);
        cur_p1_next = cur_m1;
        emit        = 1'b1;
        emit_data   = ram_rdata;
      end
      OP_SHIFT_MORE: begin
        ram_we    = 1'b1;
        sp_next   = sp_p1[IDX_W-1:0];
        ram_raddr = sp_p2[IDX_W-1:0];
      end
      OP_SHIFT_LAST: begin
        ram_we      = 1'b1;
        count_next  = count - CNT_W'(1);
        cur_p1_next = cur_m1;
        emit        = 1'b1;
        emit_data   = got;
      end
      default: begin
      end
    endcase
  end

  clc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cur_p1 <= '0;
      done   <= 1'b0;
    end else begin
      count  <= count_next;
      cur_p1 <= cur_p1_next;
      done   <= emit;
    end
    sp  <= sp_next;
    got <= got_next;
    if (emit) begin
      status      <= emit_st;
      data_out    <= emit_data;
      entry_count <= ENTRY_W'(count_next);
    end
  end

endmodule

FILE: sv/compacting_list_with_cursor_top.sv
// Channel   Beat marker            Payload
// -------   --------------------   ---------------------------------
// command   start && !busy         mode, data_in
// result    done (one cycle)       status, data_out, entry_count
//
// An insert, and any refused operation, finishes at once: its result shows
// on the cycle after the command beat, and busy stays low, so commands of
// that kind can follow back to back. First and next go through the
// registered read of the entry memory and the read state. A remove reads
// the cursor entry and then moves each entry after the cursor: one memory read per
// later entry, moved down one slot per cycle through the single write port.
// Reset is synchronous and empties the list with the cursor on no entry;
// the memory itself is not cleared, since entries at or above the count are
// never read. The receiver cannot stall, so each result is shown once.

`include "compacting_list_with_cursor_top_assert.svh"

module compacting_list_with_cursor_top import clc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  mode,
  input  logic [DATA_W-1:0]  data_in,
  output logic               done,
  output logic [STAT_W-1:0]  status,
  output logic [DATA_W-1:0]  data_out,
  output logic [ENTRY_W-1:0] entry_count
);

  clc_cmd_t   cmd;
  clc_flags_t flags;

  // The controller sequences each command; the datapath holds the list,
  // the cursor and the result registers.
  clc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .flags (flags),
    .cmd   (cmd),
    .busy  (busy)
  );

  clc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_in     (data_in),
    .flags       (flags),
    .done        (done),
    .status      (status),
    .data_out    (data_out),
    .entry_count (entry_count)
  );

  // Every accepted command either finishes at once or keeps the block busy.
  `CLC_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy, "command lost")
  // A result is never shown while a multi-cycle operation is still running.
  `CLC_ASSERT_NOW(a_no_done_busy, busy, !done, "result during busy")
  // A failed operation returns no data word.
  `CLC_ASSERT_NOW(a_fail_zero, done && (status != ST_OK), data_out == '0, "data on error")
  // A refused insert only happens on a full list.
  `CLC_ASSERT_NOW(a_full_count, done && (status == ST_FULL),
                  entry_count == ENTRY_W'(CAPACITY), "full with wrong count")

endmodule
